// ===== design/imh_pkg.sv =====
package imh_pkg;

	localparam int KEY_W     = 32;
	localparam int NODE_W    = 10;
	localparam int CNT_W     = 11;
	localparam int NODES_DEF = 1024;

	localparam logic [KEY_W-1:0] KEY_INF = '1;

	typedef enum logic [1:0] {
		REQ_RESTART = 2'd0,
		REQ_DECREASE = 2'd1,
		REQ_POP = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_RANGE = 3'd2,
		ST_NOT_SMALLER = 3'd3,
		ST_REMOVED = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [NODE_W-1:0] node;
		logic [KEY_W-1:0]  new_key;
	} in_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0]  out_key;
		logic [NODE_W-1:0] out_node;
		logic [2:0]        status;
		logic              heap_empty;
	} out_beat_t;

	typedef struct packed {
		logic key;
		logic sn;
		logic ns;
	} mem_we_t;

endpackage

// ===== design/indexed_min_heap_decrease_key.sv =====
// Indexed binary min-heap with a node-to-slot map, built around three single-port-write
// memories and one shared key comparator under a small sequencer. One request is handled
// at a time and in_stall stays high until it is done. A decrease-key that is out of range
// goes straight to the answer state, and one refused on the stored entry answers after the
// entry check. An accepted decrease-key writes its key, then climbs while its key is less
// than the parent's. A pop reads the top and last entries, then walks down, comparing the
// left and, if present, right child and swapping with a smaller one. Both walks cover at
// most 9 levels at 1024 nodes, and each step is set by the registered memory reads.
// Restart, and the start after reset, sweep all NODES entries one per cycle before the
// next request is taken; a restart answers from the done state after its sweep. Every
// answer also waits while the previous one is held in the output register. Configuration
// writes are accepted at any time, and the count is sampled at the end of a sweep.
module indexed_min_heap_decrease_key #(
	parameter int NODES = imh_pkg::NODES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [imh_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  imh_pkg::in_beat_t      in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output imh_pkg::out_beat_t     out_data
);
	import imh_pkg::*;

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CW = $clog2(NODES + 1);
	localparam int CMPW = (CW > NODE_W) ? CW : NODE_W;
	localparam int LW = AW + 2;
	localparam int RST_LIVE = (NODES < 1024) ? NODES : 1024;

	typedef enum logic [16:0] {
		S_CLEAR   = 17'h00001,
		S_IDLE    = 17'h00002,
		S_DK_CHK  = 17'h00004,
		S_UP_TEST = 17'h00008,
		S_UP_K    = 17'h00010,
		S_UP_CMP  = 17'h00020,
		S_POP_RK  = 17'h00040,
		S_POP_FIX = 17'h00080,
		S_POP_MK  = 17'h00100,
		S_DN_TEST = 17'h00200,
		S_DN_LK   = 17'h00400,
		S_DN_LC   = 17'h00800,
		S_DN_RK   = 17'h01000,
		S_DN_RC   = 17'h02000,
		S_DN_SWAP = 17'h04000,
		S_FIN     = 17'h08000,
		S_DONE    = 17'h10000
	} state_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0] node_count_q;
	logic [CW-1:0]    live_q, loaded_q, cap_count;
	logic [AW-1:0]    clr_q;
	logic             resp_q;
	logic [KEY_W-1:0] req_key_q;
	logic [AW-1:0]    req_node_q;
	logic [AW-1:0]    cur_s_q, par_s_q, par_node_q, mov_node_q, top_q;
	logic [KEY_W-1:0] mov_key_q;
	logic [AW-1:0]    best_s_q, best_node_q, cand_node_q;
	logic [KEY_W-1:0] best_key_q;
	logic [KEY_W-1:0] res_key_q;
	logic [NODE_W-1:0] res_node_q;
	status_t          res_status_q;
	out_beat_t        out_q;
	logic             out_valid_q;

	mem_we_t          we;
	logic [AW-1:0]    key_waddr, key_raddr, sn_waddr, sn_wdata, sn_raddr;
	logic [AW-1:0]    ns_waddr, ns_wdata, ns_raddr;
	logic [KEY_W-1:0] key_wdata, key_rdata;
	logic [AW-1:0]    sn_rdata, ns_rdata;

	logic [KEY_W-1:0] cmp_a, cmp_b;
	logic             cmp_lt;
	logic             accept;
	logic [LW-1:0]    left_w, right_w, live_w;
	logic [AW-1:0]    par_s;

	imh_store #(.NODES(NODES), .AW(AW)) u_store (
		.clk      (clk),
		.we       (we),
		.key_waddr(key_waddr),
		.key_wdata(key_wdata),
		.key_raddr(key_raddr),
		.key_rdata(key_rdata),
		.sn_waddr (sn_waddr),
		.sn_wdata (sn_wdata),
		.sn_raddr (sn_raddr),
		.sn_rdata (sn_rdata),
		.ns_waddr (ns_waddr),
		.ns_wdata (ns_wdata),
		.ns_raddr (ns_raddr),
		.ns_rdata (ns_rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cap_count = (32'(node_count_q) > NODES) ? CW'(NODES) : CW'(node_count_q);

	// The single key comparator, shared by every step that orders two keys.
	always_comb begin
		cmp_a = key_rdata;
		cmp_b = best_key_q;
		if (state_q == S_DK_CHK) begin
			cmp_a = req_key_q;
			cmp_b = key_rdata;
		end else if (state_q == S_UP_CMP) begin
			cmp_a = mov_key_q;
			cmp_b = key_rdata;
		end
	end
	assign cmp_lt = (cmp_a < cmp_b);

	assign left_w  = LW'({cur_s_q, 1'b1});
	assign right_w = left_w + LW'(1);
	assign live_w  = LW'(live_q);
	assign par_s   = AW'((cur_s_q - AW'(1)) >> 1);

	always_comb begin
		state_d   = state_q;
		we        = '0;
		key_waddr = clr_q;
		key_wdata = KEY_INF;
		key_raddr = req_node_q;
		sn_waddr  = clr_q;
		sn_wdata  = clr_q;
		sn_raddr  = '0;
		ns_waddr  = clr_q;
		ns_wdata  = clr_q;
		ns_raddr  = req_node_q;
		case (state_q)
			S_CLEAR: begin
				we = '{key: 1'b1, sn: 1'b1, ns: 1'b1};
				if (clr_q == AW'(NODES - 1)) begin
					state_d = resp_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					key_raddr = AW'(in_data.node);
					ns_raddr  = AW'(in_data.node);
					case (in_data.req_type)
						REQ_RESTART: state_d = S_CLEAR;
						REQ_DECREASE: begin
							if (CMPW'(in_data.node) >= CMPW'(loaded_q)) begin
								state_d = S_DONE;
							end else begin
								state_d = S_DK_CHK;
							end
						end
						REQ_POP: state_d = (live_q == '0) ? S_DONE : S_POP_RK;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_DK_CHK: begin
				if (CW'(ns_rdata) >= live_q || !cmp_lt) begin
					state_d = S_DONE;
				end else begin
					we.key    = 1'b1;
					key_waddr = req_node_q;
					key_wdata = req_key_q;
					state_d   = S_UP_TEST;
				end
			end
			S_UP_TEST: begin
				if (cur_s_q == '0) begin
					state_d = S_FIN;
				end else begin
					sn_raddr = par_s;
					state_d  = S_UP_K;
				end
			end
			S_UP_K: begin
				key_raddr = sn_rdata;
				state_d   = S_UP_CMP;
			end
			S_UP_CMP: begin
				if (cmp_lt) begin
					// Parent moves down into the hole; the climbing node is written at the end.
					we.sn    = 1'b1;
					sn_waddr = cur_s_q;
					sn_wdata = par_node_q;
					we.ns    = 1'b1;
					ns_waddr = par_node_q;
					ns_wdata = cur_s_q;
					state_d  = S_UP_TEST;
				end else begin
					state_d = S_FIN;
				end
			end
			S_POP_RK: begin
				key_raddr = sn_rdata;
				sn_raddr  = AW'(live_q - CW'(1));
				state_d   = S_POP_FIX;
			end
			S_POP_FIX: begin
				we.sn     = 1'b1;
				sn_waddr  = AW'(live_q);
				sn_wdata  = top_q;
				we.ns     = 1'b1;
				ns_waddr  = top_q;
				ns_wdata  = AW'(live_q);
				key_raddr = sn_rdata;
				state_d   = S_POP_MK;
			end
			S_POP_MK: state_d = (live_q == '0) ? S_FIN : S_DN_TEST;
			S_DN_TEST: begin
				if (left_w >= live_w) begin
					state_d = S_FIN;
				end else begin
					sn_raddr = AW'(left_w);
					state_d  = S_DN_LK;
				end
			end
			S_DN_LK: begin
				key_raddr = sn_rdata;
				state_d   = S_DN_LC;
			end
			S_DN_LC: begin
				if (right_w < live_w) begin
					sn_raddr = AW'(right_w);
					state_d  = S_DN_RK;
				end else begin
					state_d = S_DN_SWAP;
				end
			end
			S_DN_RK: begin
				key_raddr = sn_rdata;
				state_d   = S_DN_RC;
			end
			S_DN_RC: state_d = S_DN_SWAP;
			S_DN_SWAP: begin
				if (best_s_q == cur_s_q) begin
					state_d = S_FIN;
				end else begin
					we.sn    = 1'b1;
					sn_waddr = cur_s_q;
					sn_wdata = best_node_q;
					we.ns    = 1'b1;
					ns_waddr = best_node_q;
					ns_wdata = cur_s_q;
					state_d  = S_DN_TEST;
				end
			end
			S_FIN: begin
				we.sn    = 1'b1;
				sn_waddr = cur_s_q;
				sn_wdata = mov_node_q;
				we.ns    = 1'b1;
				ns_waddr = mov_node_q;
				ns_wdata = cur_s_q;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			node_count_q <= CNT_W'(1024);
			live_q       <= CW'(RST_LIVE);
			loaded_q     <= CW'(RST_LIVE);
			clr_q        <= '0;
			resp_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(NODES - 1)) begin
					live_q   <= cap_count;
					loaded_q <= cap_count;
				end
			end
			if (accept) begin
				clr_q  <= '0;
				resp_q <= 1'b1;
			end
			if (state_q == S_POP_RK) begin
				live_q <= live_q - CW'(1);
			end
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_key_q    <= in_data.new_key;
			req_node_q   <= AW'(in_data.node);
			res_key_q    <= '0;
			res_node_q   <= '0;
			if (in_data.req_type == REQ_DECREASE &&
			    CMPW'(in_data.node) >= CMPW'(loaded_q)) begin
				res_status_q <= ST_RANGE;
			end else if (in_data.req_type == REQ_POP && live_q == '0) begin
				res_status_q <= ST_EMPTY;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		case (state_q)
			S_DK_CHK: begin
				cur_s_q    <= ns_rdata;
				mov_node_q <= req_node_q;
				mov_key_q  <= req_key_q;
				if (CW'(ns_rdata) >= live_q) begin
					res_status_q <= ST_REMOVED;
				end else if (!cmp_lt) begin
					res_status_q <= ST_NOT_SMALLER;
				end
			end
			S_UP_TEST: par_s_q <= par_s;
			S_UP_K: par_node_q <= sn_rdata;
			S_UP_CMP: begin
				if (cmp_lt) begin
					cur_s_q <= par_s_q;
				end
			end
			S_POP_RK: begin
				top_q      <= sn_rdata;
				res_node_q <= NODE_W'(sn_rdata);
			end
			S_POP_FIX: begin
				res_key_q  <= key_rdata;
				mov_node_q <= sn_rdata;
				cur_s_q    <= '0;
			end
			S_POP_MK: mov_key_q <= key_rdata;
			S_DN_TEST: begin
				best_s_q   <= cur_s_q;
				best_key_q <= mov_key_q;
			end
			S_DN_LK, S_DN_RK: cand_node_q <= sn_rdata;
			S_DN_LC: begin
				if (cmp_lt) begin
					best_s_q    <= AW'(left_w);
					best_node_q <= cand_node_q;
					best_key_q  <= key_rdata;
				end
			end
			S_DN_RC: begin
				if (cmp_lt) begin
					best_s_q    <= AW'(right_w);
					best_node_q <= cand_node_q;
					best_key_q  <= key_rdata;
				end
			end
			S_DN_SWAP: cur_s_q <= best_s_q;
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_q.out_key    <= res_key_q;
					out_q.out_node   <= res_node_q;
					out_q.status     <= res_status_q;
					out_q.heap_empty <= (live_q == '0);
				end
			end
			default: ;
		endcase
	end

	a_live_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= loaded_q)
		else $error("live count exceeds loaded count");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP_RK |=> live_q == $past(live_q) - CW'(1))
		else $error("pop did not remove exactly one entry");

	a_sink_down: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DN_SWAP && best_s_q != cur_s_q |-> best_s_q > cur_s_q)
		else $error("sift-down moved toward the root");

	a_climb_up: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UP_CMP |-> par_s_q < cur_s_q)
		else $error("sift-up parent slot not above current slot");

endmodule

// ===== design/imh_store.sv =====
module imh_store #(
	parameter int NODES = 1024,
	parameter int AW = 10
) (
	input  logic                     clk,
	input  imh_pkg::mem_we_t         we,
	input  logic [AW-1:0]            key_waddr,
	input  logic [imh_pkg::KEY_W-1:0] key_wdata,
	input  logic [AW-1:0]            key_raddr,
	output logic [imh_pkg::KEY_W-1:0] key_rdata,
	input  logic [AW-1:0]            sn_waddr,
	input  logic [AW-1:0]            sn_wdata,
	input  logic [AW-1:0]            sn_raddr,
	output logic [AW-1:0]            sn_rdata,
	input  logic [AW-1:0]            ns_waddr,
	input  logic [AW-1:0]            ns_wdata,
	input  logic [AW-1:0]            ns_raddr,
	output logic [AW-1:0]            ns_rdata
);
	import imh_pkg::*;

	// Key per node, node per heap slot, and heap slot per node.
	logic [KEY_W-1:0] key_mem [NODES];
	logic [AW-1:0]    sn_mem  [NODES];
	logic [AW-1:0]    ns_mem  [NODES];

	always_ff @(posedge clk) begin
		if (we.key) begin
			key_mem[key_waddr] <= key_wdata;
		end
		key_rdata <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.sn) begin
			sn_mem[sn_waddr] <= sn_wdata;
		end
		sn_rdata <= sn_mem[sn_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.ns) begin
			ns_mem[ns_waddr] <= ns_wdata;
		end
		ns_rdata <= ns_mem[ns_raddr];
	end

endmodule
